FILE: hdl/tsc_pkg.sv
// Shared types and constants for the tile slot cache.
package tsc_pkg;

   localparam int SLOTS      = 40;
   localparam int COORD_BITS = 18;
   localparam int SLOT_BITS  = 6;
   localparam int CMD_BITS   = 2;

   localparam logic [CMD_BITS-1:0] CMD_PASS  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_REQ   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_INVAL = 2'd2;

   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [COORD_BITS-1:0] tile_x;
      logic [COORD_BITS-1:0] tile_y;
      logic                  fetch_ok;
   } req_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] slot;
      logic                 hit;
      logic                 fetch;
      logic [SLOTS-1:0]     shown_mask;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic execute;
   } ctl_type;

endpackage

FILE: hdl/tile_slot_cache.sv
// Top level of the tile slot cache: controller plus datapath.
//
// The tile slot cache manages forty fully associative slots for map tiles.
// An input beat on the req_ channel carries a command: begin a relayout pass,
// request a tile by column and row, or invalidate every slot. Every input
// beat produces exactly one result beat on the rsp_ channel, carrying the
// serving slot, the hit and fetch flags, and the mask of slots shown.
// A beat is taken at a rising edge where valid is high and stall is low.
// The block works on one beat at a time. After an input beat is accepted,
// the execute state runs the parallel tag compare, the victim priority encode
// and the flag update, and the result beat is offered from the next cycle on.
// The controller then waits for the result to be taken before it drops
// req_stall, so no new beat is taken until the previous result is gone;
// this order is set by the three-state controller sequence.
// While the receiver holds rsp_stall high the result beat stays valid and
// unchanged, and no new input beat is accepted.
// Reset clears every loaded, in-use and ever-used flag and returns the
// controller to idle; tags need no clearing because an unloaded slot never hits.
module tile_slot_cache
   import tsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_type ctl;

   // Sequencing: accept, execute, hold the result until it is taken.
   tsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   // Tag store, slot flags and the result register.
   tsc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hdl/tsc_datapath.sv
// Datapath of the tile slot cache: tag store, slot flags, lookup and victim choice.
module tsc_datapath
   import tsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  ctl_type ctl,
   input  req_type req_data,
   output rsp_type rsp_data
);

   req_type               req_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic [COORD_BITS-1:0] tag_col_ff [SLOTS];
   logic [COORD_BITS-1:0] tag_row_ff [SLOTS];
   logic [SLOTS-1:0]      loaded_ff, loaded_in;
   logic [SLOTS-1:0]      used_ff, used_in;
   logic [SLOTS-1:0]      ever_ff, ever_in;
   logic [SLOTS-1:0]      match;
   logic [SLOT_BITS-1:0]  match_idx, free_idx, idle_idx, victim, slot_sel;
   logic                  tag_wr;
   logic                  hit, fetch;

   // Lowest set bit wins.
   function automatic logic [SLOT_BITS-1:0] first_set(input logic [SLOTS-1:0] v);
      logic [SLOT_BITS-1:0] idx;
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = SLOT_BITS'(i);
         end
      end
      return idx;
   endfunction

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i] = loaded_ff[i] && (tag_col_ff[i] == req_ff.tile_x)
                    && (tag_row_ff[i] == req_ff.tile_y);
      end
   end

   assign match_idx = first_set(match);
   assign free_idx  = first_set(~ever_ff);
   assign idle_idx  = first_set(~used_ff);

   always_comb begin
      if (~&ever_ff) begin
         victim = free_idx;
      end else if (~&used_ff) begin
         victim = idle_idx;
      end else begin
         victim = '0;
      end
   end

   always_comb begin
      loaded_in = loaded_ff;
      used_in   = used_ff;
      ever_in   = ever_ff;
      tag_wr    = 1'b0;
      slot_sel  = '0;
      hit       = 1'b0;
      fetch     = 1'b0;
      if (ctl.execute) begin
         case (req_ff.cmd)
            CMD_PASS: begin
               used_in = '0;
            end
            CMD_INVAL: begin
               loaded_in = '0;
               used_in   = '0;
            end
            CMD_REQ: begin
               if (|match) begin
                  slot_sel          = match_idx;
                  hit               = 1'b1;
                  used_in[slot_sel] = 1'b1;
               end else begin
                  slot_sel            = victim;
                  fetch               = 1'b1;
                  tag_wr              = 1'b1;
                  used_in[slot_sel]   = 1'b1;
                  ever_in[slot_sel]   = 1'b1;
                  loaded_in[slot_sel] = req_ff.fetch_ok;
               end
            end
            default: begin
            end
         endcase
      end
      rsp_in.slot       = slot_sel;
      rsp_in.hit        = hit;
      rsp_in.fetch      = fetch;
      rsp_in.shown_mask = ever_in & used_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         used_ff   <= '0;
         ever_ff   <= '0;
      end else begin
         loaded_ff <= loaded_in;
         used_ff   <= used_in;
         ever_ff   <= ever_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         req_ff <= req_data;
      end
      if (ctl.execute) begin
         rsp_ff <= rsp_in;
      end
      if (tag_wr) begin
         tag_col_ff[slot_sel] <= req_ff.tile_x;
         tag_row_ff[slot_sel] <= req_ff.tile_y;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/tsc_ctrl.sv
// Controller of the tile slot cache: accept, execute and deliver sequencing.
module tsc_ctrl
   import tsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output ctl_type ctl
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      ctl.load_req = 1'b0;
      ctl.execute  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.execute = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the tile slot cache: stimulus, shadow model and result checks.
`timescale 1ns / 1ps

module tb
   import tsc_pkg::*;
();

   // The package names three commands; the fourth encoding is a no-op.
   localparam logic [CMD_BITS-1:0]   CMD_SPARE = 2'd3;
   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   // The random phase sends about this many beats. Near its end, idling stops.
   localparam int RANDOM_BEATS = 600;
   localparam int QUIET_BEATS  = 80;

   // Working set of tiles that the random phase keeps revisiting, so that hits are common.
   localparam int POOL = 48;

   // After this many results, the receiver holds off for a long stretch.
   // The sender keeps offering beats, so the single-beat pipeline fills and stalls its input.
   localparam int HOLD_AT   = 200;
   localparam int LONG_HOLD = 40;

   // A short tail covers any late result.
   localparam int TAIL_CYCLES = 12;

   // Worst case is about 650 beats. Each beat costs its pass through the controller,
   // at most one sender idle burst and at most one receiver stall burst, plus the
   // one long hold. Even so, 2 ms is many times over.
   localparam int LIMIT_NS = 2_000_000;

   // Shadow copy of the slot array. It predicts one result per accepted command and
   // holds the predictions until the matching result beats come back.
   class tile_slot_shadow;
      logic [COORD_BITS-1:0] col_tag[SLOTS];
      logic [COORD_BITS-1:0] row_tag[SLOTS];
      logic [SLOTS-1:0]      loaded;
      logic [SLOTS-1:0]      in_pass;
      logic [SLOTS-1:0]      claimed;
      rsp_type               awaited[$];
      int                    mismatches;
      int                    results_seen;

      function new();
         foreach (col_tag[i]) begin
            col_tag[i] = '0;
            row_tag[i] = '0;
         end
         loaded       = '0;
         in_pass      = '0;
         claimed      = '0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      // Applies one accepted command to the shadow state and queues the expected result.
      function void note_command(req_type beat);
         rsp_type want;
         int      match;
         int      victim;
         want = '0;
         case (beat.cmd)
            CMD_PASS: begin
               in_pass = '0;
            end
            CMD_INVAL: begin
               loaded  = '0;
               in_pass = '0;
            end
            CMD_REQ: begin
               // If several loaded slots match, the lowest one wins, so scan downward.
               match = -1;
               for (int i = SLOTS - 1; i >= 0; i--) begin
                  if (loaded[i] && col_tag[i] == beat.tile_x && row_tag[i] == beat.tile_y) begin
                     match = i;
                  end
               end
               if (match >= 0) begin
                  want.slot      = SLOT_BITS'(match);
                  want.hit       = 1'b1;
                  in_pass[match] = 1'b1;
               end else begin
                  // Take the lowest slot never claimed. If there is none, take the lowest
                  // slot not in use this pass. If every slot is in use, take slot zero.
                  victim = -1;
                  for (int i = SLOTS - 1; i >= 0; i--) begin
                     if (!claimed[i]) begin
                        victim = i;
                     end
                  end
                  if (victim < 0) begin
                     for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (!in_pass[i]) begin
                           victim = i;
                        end
                     end
                  end
                  if (victim < 0) begin
                     victim = 0;
                  end
                  want.slot       = SLOT_BITS'(victim);
                  want.fetch      = 1'b1;
                  col_tag[victim] = beat.tile_x;
                  row_tag[victim] = beat.tile_y;
                  in_pass[victim] = 1'b1;
                  claimed[victim] = 1'b1;
                  // After a failed fetch the slot keeps the new tag but can never hit.
                  loaded[victim]  = beat.fetch_ok;
               end
            end
            default: begin
               // The spare command changes nothing. Its result only reports the mask.
            end
         endcase
         want.shown_mask = claimed & in_pass;
         awaited.push_back(want);
      endfunction

      // Compares one accepted result beat with the oldest prediction.
      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected result: slot %0d hit %0b fetch %0b shown %h",
                        $realtime, got.slot, got.hit, got.fetch, got.shown_mask);
            end
            return;
         end
         want = awaited.pop_front();
         if (got.slot !== want.slot || got.hit !== want.hit || got.fetch !== want.fetch ||
             got.shown_mask !== want.shown_mask) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result %0d expected slot %0d hit %0b fetch %0b shown %h",
                        $realtime, results_seen, want.slot, want.hit, want.fetch,
                        want.shown_mask);
               $display("%0t: result %0d actual   slot %0d hit %0b fetch %0b shown %h",
                        $realtime, results_seen, got.slot, got.hit, got.fetch, got.shown_mask);
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // When set, neither side idles. It is set for the last stretch of the random phase.
   bit quiet = 1'b0;

   tile_slot_shadow shadow = new();

   tile_slot_cache u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic req_type make_beat(logic [CMD_BITS-1:0] cmd, logic [COORD_BITS-1:0] x,
                                         logic [COORD_BITS-1:0] y, logic ok);
      req_type beat;
      beat.cmd      = cmd;
      beat.tile_x   = x;
      beat.tile_y   = y;
      beat.fetch_ok = ok;
      return beat;
   endfunction

   // Offers one beat and returns at the edge where it is taken. Outside the quiet
   // stretch, a random idle burst may come first. The valid stays high on return,
   // so the caller either offers the next beat at once or lowers the valid.
   task automatic send_beat(req_type beat);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.note_command(beat);
   endtask

   // The sender goes quiet until every outstanding result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   // Receiver. At every edge it first samples the result channel as it stood at
   // that edge, then picks the stall for the next cycle. Stalls come in short
   // random bursts. One long hold, counted here in cycles, makes the block back up.
   initial begin
      int stall_left;
      bit held;
      stall_left = 0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            shadow.check_result(rsp_data);
         end
         if (!held && shadow.results_seen >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 3);
            end
         end
      end
   end

   // Sender: reset, a directed sequence, then passes of random tile requests.
   initial begin
      logic [COORD_BITS-1:0] pool_x[POOL];
      logic [COORD_BITS-1:0] pool_y[POOL];
      req_type               beat;
      int                    sent;
      int                    pass_no;
      int                    run;
      int                    pick;
      int                    slot_pick;
      bit                    long_run;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed sequence. A spare command right after reset must show an empty mask.
      // Tags are not cleared by reset, but nothing is loaded, so a request for tile (0,0)
      // must miss. Repeating the request then hits slot zero.
      send_beat(make_beat(CMD_SPARE, COORD_MAX, COORD_MAX, 1'b1));
      send_beat(make_beat(CMD_REQ, '0, '0, 1'b1));
      send_beat(make_beat(CMD_REQ, '0, '0, 1'b0));
      // A failed fetch retargets the slot but leaves it unloaded. The retry misses
      // again and lands on a fresh slot. Only after that does the tile hit.
      send_beat(make_beat(CMD_REQ, COORD_MAX, COORD_MAX, 1'b0));
      send_beat(make_beat(CMD_REQ, COORD_MAX, COORD_MAX, 1'b1));
      send_beat(make_beat(CMD_REQ, COORD_MAX, COORD_MAX, 1'b0));
      send_beat(make_beat(CMD_REQ, COORD_MAX, '0, 1'b1));
      send_beat(make_beat(CMD_REQ, '0, COORD_MAX, 1'b1));
      send_beat(make_beat(CMD_SPARE, '0, '0, 1'b0));
      // A new pass empties the shown mask. A hit in the new pass shows only its own slot.
      send_beat(make_beat(CMD_PASS, COORD_MAX, '0, 1'b1));
      send_beat(make_beat(CMD_REQ, '0, '0, 1'b1));
      send_beat(make_beat(CMD_REQ, 18'h2AAAA, 18'h15555, 1'b1));
      // Invalidation unloads everything, so known tiles miss. They take the next
      // never-claimed slots rather than reusing their old ones.
      send_beat(make_beat(CMD_INVAL, 18'h15555, 18'h2AAAA, 1'b0));
      send_beat(make_beat(CMD_REQ, '0, COORD_MAX, 1'b1));
      send_beat(make_beat(CMD_REQ, '0, COORD_MAX, 1'b1));
      send_beat(make_beat(CMD_REQ, '0, '0, 1'b1));
      send_beat(make_beat(CMD_PASS, '0, '0, 1'b0));
      send_beat(make_beat(CMD_REQ, 18'h15555, 18'h2AAAA, 1'b1));
      wait_drained();

      // The pool includes both coordinate extremes. The rest spans the full field width.
      foreach (pool_x[i]) begin
         pool_x[i] = COORD_BITS'($urandom_range(0, COORD_MAX));
         pool_y[i] = COORD_BITS'($urandom_range(0, COORD_MAX));
      end
      pool_x[0] = '0;
      pool_y[0] = '0;
      pool_x[1] = COORD_MAX;
      pool_y[1] = COORD_MAX;

      // Each pass opens with a begin-pass command, then a burst of requests. Every
      // fifth pass asks for more distinct tiles than there are slots. That first uses
      // up the never-claimed slots, then the slots idle this pass, then falls back on
      // slot zero. The shorter passes revisit the pool, with a little noise:
      // invalidations, stray begin-pass commands, spare commands and one-off tiles.
      sent    = 0;
      pass_no = 0;
      while (sent < RANDOM_BEATS) begin
         if (pass_no == 8) begin
            wait_drained();
         end
         send_beat(make_beat(CMD_PASS, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                             1'($urandom())));
         sent++;
         long_run = (pass_no % 5 == 4);
         run      = long_run ? $urandom_range(41, 48) : $urandom_range(1, 20);
         repeat (run) begin
            pick      = $urandom_range(0, 99);
            slot_pick = $urandom_range(0, POOL - 1);
            beat      = make_beat(CMD_REQ, pool_x[slot_pick], pool_y[slot_pick],
                                  $urandom_range(0, 6) != 0);
            if (long_run || pick >= 88) begin
               beat.tile_x = COORD_BITS'($urandom());
               beat.tile_y = COORD_BITS'($urandom());
            end else if (pick < 3) begin
               beat.cmd = CMD_INVAL;
            end else if (pick < 5) begin
               beat.cmd = CMD_SPARE;
            end else if (pick < 7) begin
               beat.cmd = CMD_PASS;
            end
            send_beat(beat);
            sent++;
         end
         pass_no++;
         if (sent >= RANDOM_BEATS - QUIET_BEATS) begin
            quiet = 1'b1;
         end
      end

      // Drain the results, then allow a few more cycles for any stray result beat.
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
